[hdl/ogpw_pkg.sv]
// Shared types, constants and the glyph font table for the OLED glyph page writer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ogpw_pkg;

  // Panel geometry.
  localparam int PANEL_WIDTH = 128;
  localparam int MAX_PAGES   = 8;
  localparam int TILE_W      = 8;

  // Field widths.
  localparam int PAGE_CNT_W = 4;
  localparam int DEV_ADDR_W = 7;
  localparam int BYTE_W     = 8;
  localparam int PAGE_CMD_W = 3;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  typedef enum logic [0:0] {
    REG_PAGE_COUNT     = 1'b0,
    REG_DEVICE_ADDRESS = 1'b1
  } reg_index_t;

  localparam logic [PAGE_CNT_W-1:0] PAGE_COUNT_RESET     = 4'd8;
  localparam logic [DEV_ADDR_W-1:0] DEVICE_ADDRESS_RESET = 7'd60;

  // Panel command and control bytes.
  localparam logic [BYTE_W-1:0] CTRL_COMMAND  = 8'h00;
  localparam logic [BYTE_W-1:0] CTRL_DATA     = 8'h40;
  localparam logic [BYTE_W-1:0] CMD_SET_PAGE  = 8'hB0;
  localparam logic [BYTE_W-1:0] CMD_COL_LOW   = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_COL_HIGH  = 8'h10;

  // Battery icon.
  localparam logic [BYTE_W-1:0]       BATTERY_FILL = 8'h7E;
  localparam logic [TILE_W*8-1:0]     BATTERY_BASE = 64'hFF_81_BD_BD_BD_81_FF_18;
  localparam logic [BYTE_W-1:0]       PCT_MAX      = 8'd100;

  // Printable character range of the font.
  localparam logic [BYTE_W-1:0] CHAR_FIRST  = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_LAST   = 8'd127;
  localparam int                GLYPH_COUNT = 96;
  localparam int                GLYPH_IDX_W = 7;

  // Byte sequence of one tile: three command pairs, a data control byte, eight columns.
  localparam int                 BYTES_PER_TILE = 15;
  localparam int                 STEP_W         = 4;
  localparam logic [STEP_W-1:0]  STEP_PAGE_CTRL = 4'd0;
  localparam logic [STEP_W-1:0]  STEP_PAGE      = 4'd1;
  localparam logic [STEP_W-1:0]  STEP_LOW_CTRL  = 4'd2;
  localparam logic [STEP_W-1:0]  STEP_LOW       = 4'd3;
  localparam logic [STEP_W-1:0]  STEP_HIGH_CTRL = 4'd4;
  localparam logic [STEP_W-1:0]  STEP_HIGH      = 4'd5;
  localparam logic [STEP_W-1:0]  STEP_DATA_CTRL = 4'd6;
  localparam logic [STEP_W-1:0]  STEP_DATA_0    = 4'd7;
  localparam logic [STEP_W-1:0]  STEP_LAST      = 4'(BYTES_PER_TILE - 1);

  // Tile queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [PAGE_CNT_W-1:0] page_count;
    logic [DEV_ADDR_W-1:0] device_address;
  } cfg_t;

  // One accepted tile, ready to be serialized. Column 0 of the tile is tile[0].
  typedef struct packed {
    logic [PAGE_CMD_W-1:0]         page;
    logic [BYTE_W-1:0]             column;
    logic [TILE_W-1:0][BYTE_W-1:0] tile;
  } tile_desc_t;

  // Font: first column in the top byte of each word.
  localparam logic [TILE_W*8-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
    64'h00_00_00_00_00_00_00_00, 64'h00_00_5F_00_00_00_00_00,
    64'h00_00_07_00_07_00_00_00, 64'h00_14_7F_14_7F_14_00_00,
    64'h00_24_2A_7F_2A_12_00_00, 64'h00_23_13_08_64_62_00_00,
    64'h00_36_49_55_22_50_00_00, 64'h00_00_05_03_00_00_00_00,
    64'h00_1C_22_41_00_00_00_00, 64'h00_41_22_1C_00_00_00_00,
    64'h00_08_2A_1C_2A_08_00_00, 64'h00_08_08_3E_08_08_00_00,
    64'h00_A0_60_00_00_00_00_00, 64'h00_08_08_08_08_08_00_00,
    64'h00_60_60_00_00_00_00_00, 64'h00_20_10_08_04_02_00_00,
    64'h00_3E_51_49_45_3E_00_00, 64'h00_00_42_7F_40_00_00_00,
    64'h00_62_51_49_49_46_00_00, 64'h00_22_41_49_49_36_00_00,
    64'h00_18_14_12_7F_10_00_00, 64'h00_27_45_45_45_39_00_00,
    64'h00_3C_4A_49_49_30_00_00, 64'h00_01_71_09_05_03_00_00,
    64'h00_36_49_49_49_36_00_00, 64'h00_06_49_49_29_1E_00_00,
    64'h00_00_36_36_00_00_00_00, 64'h00_00_AC_6C_00_00_00_00,
    64'h00_08_14_22_41_00_00_00, 64'h00_14_14_14_14_14_00_00,
    64'h00_41_22_14_08_00_00_00, 64'h00_02_01_51_09_06_00_00,
    64'h00_32_49_79_41_3E_00_00, 64'h00_7E_09_09_09_7E_00_00,
    64'h00_7F_49_49_49_36_00_00, 64'h00_3E_41_41_41_22_00_00,
    64'h00_7F_41_41_22_1C_00_00, 64'h00_7F_49_49_49_41_00_00,
    64'h00_7F_09_09_09_01_00_00, 64'h00_3E_41_41_51_72_00_00,
    64'h00_7F_08_08_08_7F_00_00, 64'h00_41_7F_41_00_00_00_00,
    64'h00_20_40_41_3F_01_00_00, 64'h00_7F_08_14_22_41_00_00,
    64'h00_7F_40_40_40_40_00_00, 64'h00_7F_02_0C_02_7F_00_00,
    64'h00_7F_04_08_10_7F_00_00, 64'h00_3E_41_41_41_3E_00_00,
    64'h00_7F_09_09_09_06_00_00, 64'h00_3E_41_51_21_5E_00_00,
    64'h00_7F_09_19_29_46_00_00, 64'h00_26_49_49_49_32_00_00,
    64'h00_01_01_7F_01_01_00_00, 64'h00_3F_40_40_40_3F_00_00,
    64'h00_1F_20_40_20_1F_00_00, 64'h00_3F_40_38_40_3F_00_00,
    64'h00_63_14_08_14_63_00_00, 64'h00_03_04_78_04_03_00_00,
    64'h00_61_51_49_45_43_00_00, 64'h00_7F_41_41_00_00_00_00,
    64'h00_02_04_08_10_20_00_00, 64'h00_41_41_7F_00_00_00_00,
    64'h00_04_02_01_02_04_00_00, 64'h00_80_80_80_80_80_00_00,
    64'h00_01_02_04_00_00_00_00, 64'h00_20_54_54_54_78_00_00,
    64'h00_7F_48_44_44_38_00_00, 64'h00_38_44_44_28_00_00_00,
    64'h00_38_44_44_48_7F_00_00, 64'h00_38_54_54_54_18_00_00,
    64'h00_08_7E_09_02_00_00_00, 64'h00_18_A4_A4_A4_7C_00_00,
    64'h00_7F_08_04_04_78_00_00, 64'h00_00_7D_00_00_00_00_00,
    64'h00_80_84_7D_00_00_00_00, 64'h00_7F_10_28_44_00_00_00,
    64'h00_41_7F_40_00_00_00_00, 64'h00_7C_04_18_04_78_00_00,
    64'h00_7C_08_04_7C_00_00_00, 64'h00_38_44_44_38_00_00_00,
    64'h00_FC_24_24_18_00_00_00, 64'h00_18_24_24_FC_00_00_00,
    64'h00_00_7C_08_04_00_00_00, 64'h00_48_54_54_24_00_00_00,
    64'h00_04_7F_44_00_00_00_00, 64'h00_3C_40_40_7C_00_00_00,
    64'h00_1C_20_40_20_1C_00_00, 64'h00_3C_40_30_40_3C_00_00,
    64'h00_44_28_10_28_44_00_00, 64'h00_1C_A0_A0_7C_00_00_00,
    64'h00_44_64_54_4C_44_00_00, 64'h00_08_36_41_00_00_00_00,
    64'h00_00_7F_00_00_00_00_00, 64'h00_41_36_08_00_00_00_00,
    64'h00_02_01_01_02_01_00_00, 64'h00_02_05_05_02_00_00_00
  };

endpackage

`default_nettype wire

[hdl/ogpw_regs.sv]
// Configuration registers (page count, device address) behind an APB-style port.
// Depends on ogpw_pkg.
`default_nettype none

module ogpw_regs
  import ogpw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic [PAGE_CNT_W-1:0] page_count_r, page_count_nxt;
  logic [DEV_ADDR_W-1:0] dev_addr_r, dev_addr_nxt;
  reg_index_t            reg_idx;
  logic                  wr_en;

  // Registers sit on 4-byte boundaries.
  assign reg_idx = reg_index_t'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Write decode.
  always_comb begin
    page_count_nxt = page_count_r;
    dev_addr_nxt   = dev_addr_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PAGE_COUNT:     page_count_nxt = pwdata[PAGE_CNT_W-1:0];
        REG_DEVICE_ADDRESS: dev_addr_nxt   = pwdata[DEV_ADDR_W-1:0];
        default:            page_count_nxt = page_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= PAGE_COUNT_RESET;
      dev_addr_r   <= DEVICE_ADDRESS_RESET;
    end else begin
      page_count_r <= page_count_nxt;
      dev_addr_r   <= dev_addr_nxt;
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_idx)
      REG_PAGE_COUNT:     prdata = CFG_DATA_W'(page_count_r);
      REG_DEVICE_ADDRESS: prdata = CFG_DATA_W'(dev_addr_r);
      default:            prdata = '0;
    endcase
  end

  assign cfg.page_count     = page_count_r;
  assign cfg.device_address = dev_addr_r;

endmodule

`default_nettype wire

[hdl/ogpw_front.sv]
// Front end: range checks on each request and tile build from the font or battery icon.
// Depends on ogpw_pkg; feeds the tile queue.
`default_nettype none

module ogpw_front
  import ogpw_pkg::*;
(
  input  wire logic              action,
  input  wire logic [BYTE_W-1:0] character,
  input  wire logic [BYTE_W-1:0] column,
  input  wire logic [BYTE_W-1:0] page,
  input  wire logic [BYTE_W-1:0] percentage,
  input  cfg_t                   cfg,
  output logic                   tile_ok,
  output tile_desc_t             desc
);

  logic [PAGE_CNT_W-1:0]    pages;
  logic                     page_ok;
  logic                     col_ok;
  logic [GLYPH_IDX_W-1:0]   glyph_idx;
  logic [TILE_W*8-1:0]      glyph_word;
  logic [BYTE_W-1:0]        pct_c;
  logic [BYTE_W+1:0]        pct6;
  logic [TILE_W-1:0][BYTE_W-1:0] tile;

  // A tile is dropped when its page or its last column is off the panel.
  assign pages   = (cfg.page_count < PAGE_CNT_W'(MAX_PAGES)) ? cfg.page_count
                                                             : PAGE_CNT_W'(MAX_PAGES);
  assign page_ok = page < BYTE_W'(pages);
  assign col_ok  = ({1'b0, column} + (BYTE_W+1)'(TILE_W)) <= (BYTE_W+1)'(PANEL_WIDTH);
  assign tile_ok = page_ok && col_ok;

  // Unprintable codes fall back to the space glyph at index zero.
  assign glyph_idx  = (character < CHAR_FIRST || character > CHAR_LAST) ? '0
                    : GLYPH_IDX_W'(character - CHAR_FIRST);
  assign glyph_word = GLYPH_ROM[glyph_idx];

  // Column i of the icon is filled when floor(pct*6/100) >= i, that is pct*6 >= 100*i.
  assign pct_c = (percentage > PCT_MAX) ? PCT_MAX : percentage;
  assign pct6  = ({2'b00, pct_c} << 2) + ({2'b00, pct_c} << 1);

  always_comb begin
    for (int i = 0; i < TILE_W; i++) begin
      if (action) begin
        tile[i] = BATTERY_BASE[TILE_W*8-1-8*i -: 8];
        if (i >= 1 && i <= 6 && pct6 >= (BYTE_W+2)'(100*i)) begin
          tile[i] = tile[i] | BATTERY_FILL;
        end
      end else begin
        tile[i] = glyph_word[TILE_W*8-1-8*i -: 8];
      end
    end
  end

  assign desc.page   = page[PAGE_CMD_W-1:0];
  assign desc.column = column;
  assign desc.tile   = tile;

endmodule

`default_nettype wire

[hdl/ogpw_queue.sv]
// Short tile queue that decouples request intake from byte serialization.
// Depends on ogpw_pkg.
`default_nettype none

module ogpw_queue
  import ogpw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  tile_desc_t wr_desc,
  output logic      full,
  input  wire logic rd_en,
  output tile_desc_t rd_desc,
  output logic      empty
);

  tile_desc_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;

  assign full    = count_r == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign rd_desc = mem_r[rd_ptr_r];

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en) else $error("tile queue written while full");
  a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !rd_en) else $error("tile queue read while empty");
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CNT_W'(QUEUE_DEPTH)) else $error("tile queue overfilled");
`endif

endmodule

`default_nettype wire

[hdl/ogpw_back.sv]
// Back end: serializes one queued tile into fifteen payload words with framing flags.
// Depends on ogpw_pkg; reads the tile queue.
`default_nettype none

module ogpw_back
  import ogpw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  cfg_t                       cfg,
  input  tile_desc_t                 q_desc,
  input  wire logic                  q_empty,
  output logic                       q_rd,
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [BYTE_W-1:0]     payload_byte,
  output logic                       frame_start,
  output logic                       frame_end,
  output logic      [DEV_ADDR_W-1:0] target_address,
  output logic                       last
);

  tile_desc_t        cur_r, cur_nxt;
  logic              valid_r, valid_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              taken;
  logic              done;
  logic [2:0]        data_col;

  assign taken = pop && valid_r;
  assign done  = taken && step_r == STEP_LAST;

  // Load the next tile when idle or when the last word of the current one leaves.
  assign q_rd = (!valid_r || done) && !q_empty;

  always_comb begin
    cur_nxt   = cur_r;
    valid_nxt = valid_r;
    step_nxt  = step_r;
    if (q_rd) begin
      cur_nxt   = q_desc;
      valid_nxt = 1'b1;
      step_nxt  = STEP_PAGE_CTRL;
    end else if (done) begin
      valid_nxt = 1'b0;
    end else if (taken) begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= STEP_PAGE_CTRL;
    end else begin
      valid_r <= valid_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Word select for the current step.
  assign data_col = 3'(step_r - STEP_DATA_0);

  always_comb begin
    priority if (step_r >= STEP_DATA_0) begin
      payload_byte = cur_r.tile[data_col];
    end else if (step_r == STEP_DATA_CTRL) begin
      payload_byte = CTRL_DATA;
    end else if (step_r == STEP_PAGE) begin
      payload_byte = CMD_SET_PAGE | BYTE_W'(cur_r.page);
    end else if (step_r == STEP_LOW) begin
      payload_byte = CMD_COL_LOW | {4'h0, cur_r.column[3:0]};
    end else if (step_r == STEP_HIGH) begin
      payload_byte = CMD_COL_HIGH | {4'h0, cur_r.column[7:4]};
    end else begin
      payload_byte = CTRL_COMMAND;
    end
  end

  // Framing: control bytes open a transaction, the command or last column closes it.
  assign frame_start = step_r == STEP_PAGE_CTRL || step_r == STEP_LOW_CTRL ||
                       step_r == STEP_HIGH_CTRL || step_r == STEP_DATA_CTRL;
  assign frame_end   = step_r == STEP_PAGE || step_r == STEP_LOW ||
                       step_r == STEP_HIGH || step_r == STEP_LAST;
  assign last           = step_r == STEP_LAST;
  assign target_address = cfg.device_address;
  assign empty          = !valid_r;

`ifndef NO_ASSERTIONS
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> step_r <= STEP_LAST) else $error("serializer step beyond tile end");
  a_step_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !pop) |=> (valid_r && $stable(step_r)))
    else $error("serializer advanced without a pop");
  a_drain_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (done && q_empty) |=> !valid_r) else $error("serializer did not go idle");
  a_last_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && last) |-> (frame_end && !frame_start))
    else $error("final word does not close a transaction");
`endif

endmodule

`default_nettype wire

[hdl/oled_glyph_page_writer.sv]
// OLED glyph page writer: each request becomes up to fifteen I2C payload words for one tile.
// Top level; depends on ogpw_pkg, ogpw_regs, ogpw_front, ogpw_queue and ogpw_back.
//
// Each accepted request draws one 8-column tile (a font glyph or a battery icon) and, if
// the page and column lie on the panel, produces fifteen payload words in four I2C write
// transactions: three command pairs that set page, low column and high column, then a data
// control byte and the eight tile columns. A tile leaves the result side one word per pop;
// the byte serializer in the back end sets that rate. Requests are taken one per cycle,
// while the two-tile queue is not full, so a new request is accepted while earlier tiles
// are still being sent; a request that falls off the panel is accepted but gives no words.
// The first word of a tile is visible once the back end has loaded it from the queue.
// Configuration must only be written while no tile is queued or being sent.
`default_nettype none

module oled_glyph_page_writer
  import ogpw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Request channel
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  in_action,
  input  wire logic [BYTE_W-1:0]     in_character,
  input  wire logic [BYTE_W-1:0]     in_column,
  input  wire logic [BYTE_W-1:0]     in_page,
  input  wire logic [BYTE_W-1:0]     in_percentage,
  // Result channel
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [BYTE_W-1:0]     out_payload_byte,
  output logic                       out_frame_start,
  output logic                       out_frame_end,
  output logic      [DEV_ADDR_W-1:0] out_target_address,
  output logic                       out_last,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t       cfg;
  logic       tile_ok;
  tile_desc_t front_desc;
  tile_desc_t q_desc;
  logic       q_full;
  logic       q_empty;
  logic       q_rd;
  logic       q_wr;

  ogpw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ogpw_front u_front (
    .action     (in_action),
    .character  (in_character),
    .column     (in_column),
    .page       (in_page),
    .percentage (in_percentage),
    .cfg        (cfg),
    .tile_ok    (tile_ok),
    .desc       (front_desc)
  );

  // Off-panel requests are accepted and dropped without touching the queue.
  assign full = q_full;
  assign q_wr = push && !q_full && tile_ok;

  ogpw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_desc (front_desc),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_desc (q_desc),
    .empty   (q_empty)
  );

  ogpw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_desc         (q_desc),
    .q_empty        (q_empty),
    .q_rd           (q_rd),
    .empty          (empty),
    .pop            (pop),
    .payload_byte   (out_payload_byte),
    .frame_start    (out_frame_start),
    .frame_end      (out_frame_end),
    .target_address (out_target_address),
    .last           (out_last)
  );

endmodule

`default_nettype wire

[tb/tb_oled_glyph_page_writer.sv]
// Self-checking testbench for the OLED glyph page writer: drives tile requests and
// configuration writes, predicts every I2C payload word and checks the result queue.
// Depends on ogpw_pkg and oled_glyph_page_writer.

module tb_oled_glyph_page_writer;
  timeunit 1ns;
  timeprecision 1ps;
  import ogpw_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TB_PANEL_COLS    = 128;
  localparam int TB_PAGE_LIMIT    = 8;
  localparam int TB_TILE_COLS     = 8;

  // Panel protocol bytes.
  localparam logic [7:0] I2C_CTRL_CMD  = 8'h00;
  localparam logic [7:0] I2C_CTRL_DATA = 8'h40;
  localparam logic [7:0] SET_PAGE      = 8'hB0;
  localparam logic [7:0] SET_COL_LOW   = 8'h00;
  localparam logic [7:0] SET_COL_HIGH  = 8'h10;
  localparam logic [7:0] ICON_FILL     = 8'h7E;

  // Tiles hold column 0 in the top byte.
  localparam logic [63:0] ICON_OUTLINE = 64'hFF_81_BD_BD_BD_81_FF_18;
  localparam logic [63:0] ICON_FULL    = 64'hFF_FF_FF_FF_FF_FF_FF_18;
  localparam logic [63:0] BLANK_TILE   = 64'h0;

  typedef enum logic {ACT_GLYPH = 1'b0, ACT_BATTERY = 1'b1} draw_op_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_TILE, CHK_NONE} tile_check_t;

  typedef struct packed {
    draw_op_t    action;
    logic [7:0]  character;
    logic [7:0]  column;
    logic [7:0]  page;
    logic [7:0]  percentage;
    tile_check_t check;
    logic [63:0] tile;
  } tile_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_start;
    logic       frame_end;
    logic [6:0] address;
    logic       last;
  } i2c_word_t;

  // Font for codes 32..127.
  localparam logic [63:0] FONT_COLUMNS [96] = '{
    64'h00_00_00_00_00_00_00_00, 64'h00_00_5F_00_00_00_00_00,
    64'h00_00_07_00_07_00_00_00, 64'h00_14_7F_14_7F_14_00_00,
    64'h00_24_2A_7F_2A_12_00_00, 64'h00_23_13_08_64_62_00_00,
    64'h00_36_49_55_22_50_00_00, 64'h00_00_05_03_00_00_00_00,
    64'h00_1C_22_41_00_00_00_00, 64'h00_41_22_1C_00_00_00_00,
    64'h00_08_2A_1C_2A_08_00_00, 64'h00_08_08_3E_08_08_00_00,
    64'h00_A0_60_00_00_00_00_00, 64'h00_08_08_08_08_08_00_00,
    64'h00_60_60_00_00_00_00_00, 64'h00_20_10_08_04_02_00_00,
    64'h00_3E_51_49_45_3E_00_00, 64'h00_00_42_7F_40_00_00_00,
    64'h00_62_51_49_49_46_00_00, 64'h00_22_41_49_49_36_00_00,
    64'h00_18_14_12_7F_10_00_00, 64'h00_27_45_45_45_39_00_00,
    64'h00_3C_4A_49_49_30_00_00, 64'h00_01_71_09_05_03_00_00,
    64'h00_36_49_49_49_36_00_00, 64'h00_06_49_49_29_1E_00_00,
    64'h00_00_36_36_00_00_00_00, 64'h00_00_AC_6C_00_00_00_00,
    64'h00_08_14_22_41_00_00_00, 64'h00_14_14_14_14_14_00_00,
    64'h00_41_22_14_08_00_00_00, 64'h00_02_01_51_09_06_00_00,
    64'h00_32_49_79_41_3E_00_00, 64'h00_7E_09_09_09_7E_00_00,
    64'h00_7F_49_49_49_36_00_00, 64'h00_3E_41_41_41_22_00_00,
    64'h00_7F_41_41_22_1C_00_00, 64'h00_7F_49_49_49_41_00_00,
    64'h00_7F_09_09_09_01_00_00, 64'h00_3E_41_41_51_72_00_00,
    64'h00_7F_08_08_08_7F_00_00, 64'h00_41_7F_41_00_00_00_00,
    64'h00_20_40_41_3F_01_00_00, 64'h00_7F_08_14_22_41_00_00,
    64'h00_7F_40_40_40_40_00_00, 64'h00_7F_02_0C_02_7F_00_00,
    64'h00_7F_04_08_10_7F_00_00, 64'h00_3E_41_41_41_3E_00_00,
    64'h00_7F_09_09_09_06_00_00, 64'h00_3E_41_51_21_5E_00_00,
    64'h00_7F_09_19_29_46_00_00, 64'h00_26_49_49_49_32_00_00,
    64'h00_01_01_7F_01_01_00_00, 64'h00_3F_40_40_40_3F_00_00,
    64'h00_1F_20_40_20_1F_00_00, 64'h00_3F_40_38_40_3F_00_00,
    64'h00_63_14_08_14_63_00_00, 64'h00_03_04_78_04_03_00_00,
    64'h00_61_51_49_45_43_00_00, 64'h00_7F_41_41_00_00_00_00,
    64'h00_02_04_08_10_20_00_00, 64'h00_41_41_7F_00_00_00_00,
    64'h00_04_02_01_02_04_00_00, 64'h00_80_80_80_80_80_00_00,
    64'h00_01_02_04_00_00_00_00, 64'h00_20_54_54_54_78_00_00,
    64'h00_7F_48_44_44_38_00_00, 64'h00_38_44_44_28_00_00_00,
    64'h00_38_44_44_48_7F_00_00, 64'h00_38_54_54_54_18_00_00,
    64'h00_08_7E_09_02_00_00_00, 64'h00_18_A4_A4_A4_7C_00_00,
    64'h00_7F_08_04_04_78_00_00, 64'h00_00_7D_00_00_00_00_00,
    64'h00_80_84_7D_00_00_00_00, 64'h00_7F_10_28_44_00_00_00,
    64'h00_41_7F_40_00_00_00_00, 64'h00_7C_04_18_04_78_00_00,
    64'h00_7C_08_04_7C_00_00_00, 64'h00_38_44_44_38_00_00_00,
    64'h00_FC_24_24_18_00_00_00, 64'h00_18_24_24_FC_00_00_00,
    64'h00_00_7C_08_04_00_00_00, 64'h00_48_54_54_24_00_00_00,
    64'h00_04_7F_44_00_00_00_00, 64'h00_3C_40_40_7C_00_00_00,
    64'h00_1C_20_40_20_1C_00_00, 64'h00_3C_40_30_40_3C_00_00,
    64'h00_44_28_10_28_44_00_00, 64'h00_1C_A0_A0_7C_00_00_00,
    64'h00_44_64_54_4C_44_00_00, 64'h00_08_36_41_00_00_00_00,
    64'h00_00_7F_00_00_00_00_00, 64'h00_41_36_08_00_00_00_00,
    64'h00_02_01_01_02_01_00_00, 64'h00_02_05_05_02_00_00_00
  };

  // Directed requests at reset configuration; typed tiles are read straight off the spec.
  tile_req_t directed_rows [0:23] = '{
    '{ACT_GLYPH,   8'd65,  8'd0,   8'd0,   8'd0,   CHK_MODEL, BLANK_TILE},
    '{ACT_GLYPH,   8'd0,   8'd120, 8'd7,   8'd0,   CHK_TILE,  BLANK_TILE},
    '{ACT_GLYPH,   8'd31,  8'd15,  8'd1,   8'd255, CHK_TILE,  BLANK_TILE},
    '{ACT_GLYPH,   8'd32,  8'd16,  8'd2,   8'd0,   CHK_TILE,  BLANK_TILE},
    '{ACT_GLYPH,   8'd33,  8'd7,   8'd6,   8'd0,   CHK_TILE,  64'h00_00_5F_00_00_00_00_00},
    '{ACT_GLYPH,   8'd127, 8'd85,  8'd2,   8'd0,   CHK_TILE,  64'h00_02_05_05_02_00_00_00},
    '{ACT_GLYPH,   8'd128, 8'd112, 8'd5,   8'd0,   CHK_TILE,  BLANK_TILE},
    '{ACT_GLYPH,   8'd255, 8'd64,  8'd3,   8'd0,   CHK_TILE,  BLANK_TILE},
    '{ACT_GLYPH,   8'd126, 8'd15,  8'd0,   8'd100, CHK_MODEL, BLANK_TILE},
    '{ACT_GLYPH,   8'd103, 8'd120, 8'd4,   8'd0,   CHK_MODEL, BLANK_TILE},
    '{ACT_BATTERY, 8'd255, 8'd8,   8'd4,   8'd0,   CHK_TILE,  ICON_OUTLINE},
    '{ACT_BATTERY, 8'd65,  8'd0,   8'd0,   8'd16,  CHK_TILE,  ICON_OUTLINE},
    '{ACT_BATTERY, 8'd0,   8'd24,  8'd1,   8'd17,  CHK_TILE,  64'hFF_FF_BD_BD_BD_81_FF_18},
    '{ACT_BATTERY, 8'd0,   8'd40,  8'd3,   8'd50,  CHK_MODEL, BLANK_TILE},
    '{ACT_BATTERY, 8'd0,   8'd48,  8'd5,   8'd99,  CHK_MODEL, BLANK_TILE},
    '{ACT_BATTERY, 8'd0,   8'd120, 8'd7,   8'd100, CHK_TILE,  ICON_FULL},
    '{ACT_BATTERY, 8'd0,   8'd0,   8'd6,   8'd101, CHK_TILE,  ICON_FULL},
    '{ACT_BATTERY, 8'd0,   8'd96,  8'd2,   8'd255, CHK_TILE,  ICON_FULL},
    '{ACT_GLYPH,   8'd65,  8'd0,   8'd8,   8'd0,   CHK_NONE,  BLANK_TILE},
    '{ACT_BATTERY, 8'd0,   8'd255, 8'd255, 8'd50,  CHK_NONE,  BLANK_TILE},
    '{ACT_GLYPH,   8'd66,  8'd121, 8'd0,   8'd0,   CHK_NONE,  BLANK_TILE},
    '{ACT_GLYPH,   8'd66,  8'd128, 8'd7,   8'd0,   CHK_NONE,  BLANK_TILE},
    '{ACT_GLYPH,   8'd90,  8'd170, 8'd0,   8'd0,   CHK_NONE,  BLANK_TILE},
    '{ACT_BATTERY, 8'd0,   8'd0,   8'd248, 8'd100, CHK_NONE,  BLANK_TILE}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  push, full;
  logic                  in_action;
  logic [BYTE_W-1:0]     in_character, in_column, in_page, in_percentage;
  logic                  empty, pop;
  logic [BYTE_W-1:0]     out_payload_byte;
  logic                  out_frame_start, out_frame_end, out_last;
  logic [DEV_ADDR_W-1:0] out_target_address;
  logic                  psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  i2c_word_t   expected_words [$];
  tile_req_t   offered_req;
  logic [3:0]  page_count_q;
  logic [6:0]  dev_addr_q;
  int          error_count = 0;
  int          cycle_count = 0;
  int          tiles_drawn;
  bit          hold_off_req = 1'b0;

  oled_glyph_page_writer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_action          (in_action),
    .in_character       (in_character),
    .in_column          (in_column),
    .in_page            (in_page),
    .in_percentage      (in_percentage),
    .empty              (empty),
    .pop                (pop),
    .out_payload_byte   (out_payload_byte),
    .out_frame_start    (out_frame_start),
    .out_frame_end      (out_frame_end),
    .out_target_address (out_target_address),
    .out_last           (out_last),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #5 clk = ~clk;

  // Eight tile columns for a glyph or a battery icon.
  function automatic logic [63:0] render_tile(draw_op_t op, logic [7:0] code, logic [7:0] pct);
    logic [63:0] cols;
    int          charge;
    int          fill;
    if (op == ACT_GLYPH) begin
      // Unprintable codes fall back to a space.
      if (code < 8'd32 || code > 8'd127) code = 8'd32;
      cols = FONT_COLUMNS[int'(code) - 32];
    end else begin
      charge = (pct > 8'd100) ? 100 : int'(pct);
      fill = charge * 6 / 100;
      cols = ICON_OUTLINE;
      for (int i = 1; i <= fill; i++) cols[63 - 8 * i -: 8] = cols[63 - 8 * i -: 8] | ICON_FILL;
    end
    return cols;
  endfunction

  function automatic bit tile_on_panel(logic [7:0] page, logic [7:0] column);
    int pages;
    pages = (int'(page_count_q) < TB_PAGE_LIMIT) ? int'(page_count_q) : TB_PAGE_LIMIT;
    return (int'(page) < pages) && (int'(column) + TB_TILE_COLS <= TB_PANEL_COLS);
  endfunction

  function automatic void add_word(logic [7:0] data, bit first, bit closing, bit final_word);
    expected_words.push_back('{data, first, closing, dev_addr_q, final_word});
  endfunction

  // Fifteen words per tile that lands on the panel: three command pairs, then the data frame.
  function automatic void queue_tile_words(tile_req_t r);
    logic [63:0] cols;
    if (r.check == CHK_NONE) return;
    if (r.check == CHK_MODEL && !tile_on_panel(r.page, r.column)) return;
    cols = (r.check == CHK_TILE) ? r.tile : render_tile(r.action, r.character, r.percentage);
    add_word(I2C_CTRL_CMD, 1'b1, 1'b0, 1'b0);
    add_word(SET_PAGE | {5'd0, r.page[2:0]}, 1'b0, 1'b1, 1'b0);
    add_word(I2C_CTRL_CMD, 1'b1, 1'b0, 1'b0);
    add_word(SET_COL_LOW | {4'd0, r.column[3:0]}, 1'b0, 1'b1, 1'b0);
    add_word(I2C_CTRL_CMD, 1'b1, 1'b0, 1'b0);
    add_word(SET_COL_HIGH | {4'd0, r.column[7:4]}, 1'b0, 1'b1, 1'b0);
    add_word(I2C_CTRL_DATA, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < TB_TILE_COLS; i++)
      add_word(cols[63 - 8 * i -: 8], 1'b0, i == TB_TILE_COLS - 1, i == TB_TILE_COLS - 1);
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Mostly tiles that land on the panel when any page is enabled, the rest anywhere in the field ranges.
  function automatic tile_req_t random_req();
    tile_req_t r;
    int        pages;
    pages = (int'(page_count_q) < TB_PAGE_LIMIT) ? int'(page_count_q) : TB_PAGE_LIMIT;
    r.check = CHK_MODEL;
    r.tile = BLANK_TILE;
    r.action = draw_op_t'($urandom_range(0, 1));
    r.character = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(32, 127))
                                              : 8'($urandom_range(0, 255));
    r.percentage = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 100))
                                               : 8'($urandom_range(0, 255));
    if (pages > 0 && $urandom_range(0, 9) < 8) begin
      r.page = 8'($urandom_range(0, pages - 1));
      r.column = 8'($urandom_range(0, TB_PANEL_COLS - TB_TILE_COLS));
    end else begin
      r.page = 8'($urandom_range(0, 255));
      r.column = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  // Predict on every accepted request, check on every accepted word.
  always @(posedge clk) begin
    tile_req_t seen;
    i2c_word_t want;
    if (rst_n && push && !full) begin
      seen = offered_req;
      seen.action = draw_op_t'(in_action);
      seen.character = in_character;
      seen.column = in_column;
      seen.page = in_page;
      seen.percentage = in_percentage;
      queue_tile_words(seen);
    end
    if (rst_n && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word 0x%0h with nothing expected", out_payload_byte);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        compare_field("payload_byte", want.data, out_payload_byte);
        compare_field("frame_start", 8'(want.frame_start), 8'(out_frame_start));
        compare_field("frame_end", 8'(want.frame_end), 8'(out_frame_end));
        compare_field("target_address", 8'(want.address), 8'(out_target_address));
        compare_field("last", 8'(want.last), 8'(out_last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[oled_glyph_page_writer] ERROR");
      $finish;
    end
  end

  // Receiver: a randomly chosen stall pattern for each random stretch, plus one long hold.
  initial begin
    int mode;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        repeat ($urandom_range(10, 60)) begin
          @(negedge clk);
          case (mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 99) >= 25);
            2: pop <= ($urandom_range(0, 99) >= 75);
            default: pop <= ~pop;
          endcase
        end
      end
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic offer(tile_req_t r);
    @(negedge clk);
    if (r.check == CHK_MODEL && tile_on_panel(r.page, r.column)) tiles_drawn++;
    offered_req = r;
    push <= 1'b1;
    in_action <= r.action;
    in_character <= r.character;
    in_column <= r.column;
    in_page <= r.page;
    in_percentage <= r.percentage;
    do @(posedge clk); while (full);
  endtask

  task automatic rest(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  // Stop sending and wait until every expected word has been popped.
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_PAGE_COUNT) page_count_q = value[3:0];
    else dev_addr_q = value[6:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Bursts of random requests until enough tiles have been drawn.
  task automatic run_random(int target, bit long_hold, bit pause_midway);
    bit paused;
    paused = 1'b0;
    tiles_drawn = 0;
    if (long_hold) hold_off_req = 1'b1;
    while (tiles_drawn < target) begin
      repeat ($urandom_range(1, 8)) offer(random_req());
      if (pause_midway && !paused && tiles_drawn >= target / 2) begin
        wait_idle();
        paused = 1'b1;
      end else if (!hold_off_req && $urandom_range(0, 3) != 0) begin
        rest($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_action = 1'b0;
    in_character = '0;
    in_column = '0;
    in_page = '0;
    in_percentage = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    page_count_q = 4'd8;
    dev_addr_q = 7'd60;
    offered_req = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at reset configuration.
    foreach (directed_rows[i]) begin
      offer(directed_rows[i]);
      if ($urandom_range(0, 2) == 0) rest($urandom_range(1, 4));
    end
    wait_idle();

    // Single page, lowest address.
    write_reg(REG_PAGE_COUNT, 32'd1);
    write_reg(REG_DEVICE_ADDRESS, 32'd0);
    run_random(10, 1'b0, 1'b0);
    wait_idle();

    // No pages at all: every tile is dropped.
    write_reg(REG_PAGE_COUNT, 32'd0);
    write_reg(REG_DEVICE_ADDRESS, 32'd127);
    repeat (12) offer(random_req());
    wait_idle();

    // Count above the panel's pages; the receiver holds off so the input stalls.
    write_reg(REG_PAGE_COUNT, 32'd15);
    run_random(15, 1'b1, 1'b0);
    wait_idle();

    // Full panel with a sender pause until the result side drains.
    write_reg(REG_PAGE_COUNT, 32'd8);
    write_reg(REG_DEVICE_ADDRESS, 32'($urandom_range(1, 126)));
    run_random(15, 1'b0, 1'b1);
    wait_idle();

    write_reg(REG_PAGE_COUNT, 32'($urandom_range(2, 7)));
    write_reg(REG_DEVICE_ADDRESS, 32'($urandom_range(0, 127)));
    run_random(15, 1'b0, 1'b0);
    wait_idle();

    if (error_count == 0) begin
      $display("[oled_glyph_page_writer] OK");
    end else begin
      $display("[oled_glyph_page_writer] ERROR");
    end
    $finish;
  end

endmodule
